// ===== rtl/tcc_pkg.sv =====
package tcc_pkg;

	localparam int unsigned TAB_PITCH = 8;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET    = 7'd24;

	// configuration register indexes
	localparam logic [1:0] REG_COLUMNS   = 2'd0;
	localparam logic [1:0] REG_ROWS      = 2'd1;
	localparam logic [1:0] REG_AUTO_WRAP = 2'd2;
	localparam logic [1:0] REG_REL_ORG   = 2'd3;

	typedef enum logic [3:0] {
		CMD_PUT     = 4'd0,
		CMD_MOVETO  = 4'd1,
		CMD_UP      = 4'd2,
		CMD_DOWN    = 4'd3,
		CMD_LEFT    = 4'd4,
		CMD_RIGHT   = 4'd5,
		CMD_HOME    = 4'd6,
		CMD_END     = 4'd7,
		CMD_NEWLINE = 4'd8,
		CMD_TABR    = 4'd9,
		CMD_TABL    = 4'd10,
		CMD_SETTAB  = 4'd11,
		CMD_CLRTAB  = 4'd12,
		CMD_CLRALL  = 4'd13,
		CMD_MARGINS = 4'd14,
		CMD_RESET   = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_WALK = 2'd2,
		S_DONE = 2'd3
	} state_t;

	typedef enum logic [2:0] {
		TAB_NONE    = 3'd0,
		TAB_SET     = 3'd1,
		TAB_CLR     = 3'd2,
		TAB_CLR_ALL = 3'd3,
		TAB_DEFAULT = 3'd4
	} tab_op_t;

	typedef struct packed {
		logic load;
		logic walk_start;
		logic walk_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_walk;
		logic walk_done;
	} dp_status_t;

	// saturate a size register to 1..hi
	function automatic logic [8:0] clamp_size(input logic [8:0] v, input logic [8:0] hi);
		logic [8:0] r;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/tcc_ctrl.sv =====
module tcc_ctrl
	import tcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.need_walk) begin
					cmd.walk_start = 1'b1;
					state_d        = S_WALK;
				end else if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
		endcase
	end

endmodule

// ===== rtl/tcc_tab_walker.sv =====
module tcc_tab_walker
	import tcc_pkg::*;
#(
	parameter int MAX_COLS = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [$clog2(MAX_COLS+1)-1:0]  c_eff,
	input  logic                           start,
	input  logic                           step,
	input  logic                           dir_left,
	input  logic [$clog2(MAX_COLS+1)-1:0]  start_col,
	input  logic [7:0]                     count,
	output logic                           done,
	output logic [$clog2(MAX_COLS+1)-1:0]  res_col,
	input  logic                           op_en,
	input  tab_op_t                        op,
	input  logic [$clog2(MAX_COLS+1)-1:0]  op_col
);

	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int PW = CW + 2;
	localparam int TI = $clog2(MAX_COLS);
	localparam logic signed [PW-1:0] ONE = PW'(1);

	logic [MAX_COLS-1:0]     stops_q;
	logic signed [PW-1:0]    pos_q, pos_d, res, c_s, start_s;
	logic [7:0]              rem_q, rem_d;
	logic                    left_q;
	logic                    hit;

	assign c_s     = $signed({2'b00, c_eff});
	assign start_s = $signed({2'b00, start_col});
	assign res_col = pos_q[CW-1:0];

	// one column per cycle; a stop decrements the remaining count
	always_comb begin
		done  = 1'b0;
		hit   = 1'b0;
		res   = pos_q;
		pos_d = pos_q;
		rem_d = rem_q;
		if (left_q) begin
			if (pos_q[PW-1] || pos_q == '0) begin
				done = 1'b1;
				res  = '0;
			end else begin
				hit = stops_q[pos_q[TI-1:0]];
				if (hit && rem_q == 8'd1) begin
					done = 1'b1;
				end else begin
					pos_d = pos_q - ONE;
					if (hit) begin
						rem_d = rem_q - 8'd1;
					end
				end
			end
		end else begin
			if (pos_q >= c_s) begin
				done = 1'b1;
				res  = c_s - ONE;
			end else begin
				hit = stops_q[pos_q[TI-1:0]];
				if (hit && (rem_q == 8'd1 || pos_q == c_s - ONE)) begin
					done = 1'b1;
				end else begin
					pos_d = pos_q + ONE;
					if (hit) begin
						rem_d = rem_q - 8'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pos_q  <= dir_left ? start_s - ONE : start_s + ONE;
			rem_q  <= count;
			left_q <= dir_left;
		end else if (step) begin
			pos_q <= done ? res : pos_d;
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_COLS; i++) begin
				stops_q[i] <= ((i % TAB_PITCH) == 0);
			end
		end else if (op_en) begin
			unique case (op)
				TAB_NONE: begin
				end
				TAB_SET: stops_q[op_col[TI-1:0]] <= 1'b1;
				TAB_CLR: stops_q[op_col[TI-1:0]] <= 1'b0;
				TAB_CLR_ALL: stops_q <= '0;
				TAB_DEFAULT: begin
					for (int i = 0; i < MAX_COLS; i++) begin
						stops_q[i] <= ((i % TAB_PITCH) == 0);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/tcc_datapath.sv =====
module tcc_datapath
	import tcc_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic [3:0]  command,
	input  logic [7:0]  count,
	input  logic [7:0]  target_col,
	input  logic [7:0]  target_row,
	input  logic        scroll_allowed,
	input  logic [1:0]  symbol_width,
	input  logic [20:0] symbol_code,
	input  logic [7:0]  margin_first,
	input  logic [7:0]  margin_last,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  sts,
	output logic [7:0]  cursor_col,
	output logic [5:0]  cursor_row,
	output logic        write_enable,
	output logic [6:0]  write_col,
	output logic [5:0]  write_row,
	output logic [20:0] write_symbol,
	output logic [1:0]  write_span,
	output logic [6:0]  scroll_up_lines,
	output logic [6:0]  scroll_down_lines
);

	localparam int CW  = $clog2(MAX_COLS + 1);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam logic [8:0] MAXC = 9'(MAX_COLS);
	localparam logic [8:0] MAXR = 9'(MAX_ROWS);
	localparam logic [8:0] ROWS_RST_EFF = (9'(ROWS_RESET) > MAXR) ? MAXR : 9'(ROWS_RESET);

	// configuration and persistent state
	logic [7:0]    columns_q;
	logic [6:0]    rows_q;
	logic          wrap_q, origin_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q, top_q, bot_q;

	// latched command word
	cmd_t          cmd_q;
	logic [7:0]    count_q, tcol_q, trow_q, mfirst_q, mlast_q;
	logic          scroll_q;
	logic [1:0]    swidth_q;
	logic [20:0]   scode_q;

	logic [CW-1:0]  c_eff;
	logic [RCW-1:0] r_eff;
	logic [8:0]     cfg_c9, cfg_r9;
	logic [CW-1:0]  cfg_col;
	logic [RW-1:0]  cfg_row, cfg_bot;
	logic           size_write;

	// next-state scratch
	logic [9:0] c, r, col, row, top, bot, h, num, last, lim, diff, x, sw, mf;
	logic       scr, we;
	logic [9:0] wc, wr, sup, sdn;
	logic [1:0] wsp;
	tab_op_t    tab_op, walk_op;
	logic       walk_op_en;

	logic          walk_done;
	logic [CW-1:0] walk_col;

	assign c_eff = CW'(clamp_size({1'b0, columns_q}, MAXC));
	assign r_eff = RCW'(clamp_size({2'b00, rows_q}, MAXR));

	assign sts.need_walk = (cmd_q == CMD_TABR || cmd_q == CMD_TABL) && count_q != 8'd0;
	assign sts.walk_done = walk_done;

	// size writes: full region, default stops, cursor pulled inside
	assign size_write = cfg_we && (cfg_index == REG_COLUMNS || cfg_index == REG_ROWS);
	assign cfg_c9 = clamp_size({1'b0, (cfg_index == REG_COLUMNS) ? cfg_data : columns_q}, MAXC);
	assign cfg_r9 = clamp_size({2'b00, (cfg_index == REG_ROWS) ? cfg_data[6:0] : rows_q}, MAXR);
	assign cfg_col = (9'(col_q) >= cfg_c9) ? CW'(cfg_c9 - 9'd1) : col_q;
	assign cfg_row = (9'(row_q) >= cfg_r9) ? RW'(cfg_r9 - 9'd1) : row_q;
	assign cfg_bot = RW'(cfg_r9 - 9'd1);

	always_comb begin
		c    = 10'(c_eff);
		r    = 10'(r_eff);
		col  = 10'(col_q);
		row  = 10'(row_q);
		top  = 10'(top_q);
		bot  = 10'(bot_q);
		h    = bot + 10'd1 - top;
		num  = 10'(count_q);
		scr  = scroll_q;
		last = '0;
		lim  = '0;
		diff = '0;
		x    = '0;
		sw   = '0;
		mf   = '0;
		we   = 1'b0;
		wc   = '0;
		wr   = '0;
		wsp  = '0;
		sup  = '0;
		sdn  = '0;
		tab_op = TAB_NONE;
		unique case (cmd_q)
			CMD_PUT: begin
				if (swidth_q != 2'd0) begin
					sw = (swidth_q == 2'd3) ? 10'd2 : 10'(swidth_q);
					last = (row <= bot || row >= r) ? bot : r - 10'd1;
					if (col >= c) begin
						if (wrap_q) begin
							col = '0;
							row = row + 10'd1;
						end else begin
							col = c - 10'd1;
						end
					end
					if (row > last) begin
						row = last;
						sup = 10'd1;   // region is never empty
					end
					we  = 1'b1;
					wc  = col;
					wr  = row;
					wsp = sw[1:0];
					col = col + sw;
					if (col > c) begin
						col = c;
					end
				end
			end
			CMD_MOVETO: begin
				last = origin_q ? bot : r - 10'd1;
				col  = (10'(tcol_q) >= c) ? c - 10'd1 : 10'(tcol_q);
				x    = origin_q ? top + 10'(trow_q) : 10'(trow_q);
				row  = (x > last) ? last : x;
			end
			CMD_UP: begin
				if (num != '0) begin
					lim  = (row >= top) ? top : '0;
					diff = row - lim;
					if (num > diff) begin
						if (scr) begin
							sdn = (num - diff > h) ? h : num - diff;
						end
						row = lim;
					end else begin
						row = row - num;
					end
				end
			end
			CMD_DOWN, CMD_NEWLINE: begin
				if (cmd_q == CMD_NEWLINE) begin
					num = 10'd1;
					scr = 1'b1;
				end
				lim  = (row <= bot) ? bot + 10'd1 : r;
				diff = lim - row - 10'd1;
				if (num > diff) begin
					if (scr) begin
						sup = (num - diff > h) ? h : num - diff;
					end
					row = lim - 10'd1;
				end else begin
					row = row + num;
				end
				if (cmd_q == CMD_NEWLINE) begin
					col = '0;
				end
			end
			CMD_LEFT: begin
				if (num != '0) begin
					if (num > c) begin
						num = c;
					end
					x   = (col >= c) ? c - 10'd1 : col;
					col = (num > x) ? '0 : x - num;
				end
			end
			CMD_RIGHT: begin
				if (num != '0) begin
					if (num > c) begin
						num = c;
					end
					col = (num + col >= c) ? c - 10'd1 : col + num;
				end
			end
			CMD_HOME: col = '0;
			CMD_END:  col = c - 10'd1;
			CMD_TABR, CMD_TABL: begin
				if (num != '0) begin
					col = 10'(walk_col);
				end
			end
			CMD_SETTAB: begin
				if (col < c) begin
					tab_op = TAB_SET;
				end
			end
			CMD_CLRTAB: begin
				if (col < c) begin
					tab_op = TAB_CLR;
				end
			end
			CMD_CLRALL: tab_op = TAB_CLR_ALL;
			CMD_MARGINS: begin
				mf = (mfirst_q == 8'd0) ? 10'd1 : 10'(mfirst_q);
				if (10'(mlast_q) <= mf || 10'(mlast_q) > r) begin
					top = '0;
					bot = r - 10'd1;
				end else begin
					top = mf - 10'd1;
					bot = 10'(mlast_q) - 10'd1;
				end
			end
			CMD_RESET: begin
				top    = '0;
				bot    = r - 10'd1;
				tab_op = TAB_DEFAULT;
			end
		endcase
	end

	assign walk_op_en = size_write || cmd.commit;
	assign walk_op    = size_write ? TAB_DEFAULT : tab_op;

	tcc_tab_walker #(
		.MAX_COLS (MAX_COLS)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.c_eff     (c_eff),
		.start     (cmd.walk_start),
		.step      (cmd.walk_step),
		.dir_left  (cmd_q == CMD_TABL),
		.start_col (col_q),
		.count     (count_q),
		.done      (walk_done),
		.res_col   (walk_col),
		.op_en     (walk_op_en),
		.op        (walk_op),
		.op_col    (col_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
			wrap_q    <= 1'b0;
			origin_q  <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			top_q     <= '0;
			bot_q     <= RW'(ROWS_RST_EFF - 9'd1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS:   columns_q <= cfg_data;
				REG_ROWS:      rows_q    <= cfg_data[6:0];
				REG_AUTO_WRAP: wrap_q    <= cfg_data[0];
				REG_REL_ORG:   origin_q  <= cfg_data[0];
			endcase
			if (size_write) begin
				col_q <= cfg_col;
				row_q <= cfg_row;
				top_q <= '0;
				bot_q <= cfg_bot;
			end
		end else if (cmd.commit) begin
			col_q <= CW'(col);
			row_q <= RW'(row);
			top_q <= RW'(top);
			bot_q <= RW'(bot);
		end
	end

	// command word and result word: payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= cmd_t'(command);
			count_q  <= count;
			tcol_q   <= target_col;
			trow_q   <= target_row;
			scroll_q <= scroll_allowed;
			swidth_q <= symbol_width;
			scode_q  <= symbol_code;
			mfirst_q <= margin_first;
			mlast_q  <= margin_last;
		end
		if (cmd.commit) begin
			cursor_col        <= col[7:0];
			cursor_row        <= row[5:0];
			write_enable      <= we;
			write_col         <= wc[6:0];
			write_row         <= wr[5:0];
			write_symbol      <= we ? scode_q : '0;
			write_span        <= wsp;
			scroll_up_lines   <= sup[6:0];
			scroll_down_lines <= sdn[6:0];
		end
	end

endmodule

// ===== rtl/terminal_cursor_tab_controller.sv =====
// Cursor and tab-stop engine for a VT100-style text terminal. Each input word
// carries one command (put symbol, absolute or relative cursor moves, home/end,
// newline, tab right/left, tab-stop set/clear, scroll margins, soft reset) and
// yields exactly one result word: the cursor after the command, an optional
// cell write (position, code, span) and the number of lines the margin region
// has to scroll up or down. An accepted command is latched, executed and then
// committed into the result register once the result slot is free; only then
// is the next command taken. Tab right/left with a nonzero count go through
// the tab-stop walker, which visits one column per cycle, before the commit.
// The result register lets the next command be accepted while a result is
// still waiting to be taken; a command completes only once that slot is free.
// Configuration writes (columns, rows, auto_wrap, relative_origin) must be
// issued while the block is idle; writing columns or rows restores full
// margins and the default stops (every eighth column) and pulls the cursor
// inside the new screen. The effective sizes saturate to 1..MAX_COLS/MAX_ROWS.
module terminal_cursor_tab_controller
	import tcc_pkg::*;
#(
	parameter int MAX_COLS = 128,  // tab-stop storage depth
	parameter int MAX_ROWS = 64    // row range of cursor and margins
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// command channel
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [3:0]  command,
	input  logic [7:0]  count,
	input  logic [7:0]  target_col,
	input  logic [7:0]  target_row,
	input  logic        scroll_allowed,
	input  logic [1:0]  symbol_width,
	input  logic [20:0] symbol_code,
	input  logic [7:0]  margin_first,
	input  logic [7:0]  margin_last,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  cursor_col,
	output logic [5:0]  cursor_row,
	output logic        write_enable,
	output logic [6:0]  write_col,
	output logic [5:0]  write_row,
	output logic [20:0] write_symbol,
	output logic [1:0]  write_span,
	output logic [6:0]  scroll_up_lines,
	output logic [6:0]  scroll_down_lines
);

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	// sequencer: accept, execute, optional tab walk, commit into result reg
	tcc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (ctl)
	);

	// cursor, margins, tab stops and the result word
	tcc_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.command           (command),
		.count             (count),
		.target_col        (target_col),
		.target_row        (target_row),
		.scroll_allowed    (scroll_allowed),
		.symbol_width      (symbol_width),
		.symbol_code       (symbol_code),
		.margin_first      (margin_first),
		.margin_last       (margin_last),
		.cmd               (ctl),
		.sts               (sts),
		.cursor_col        (cursor_col),
		.cursor_row        (cursor_row),
		.write_enable      (write_enable),
		.write_col         (write_col),
		.write_row         (write_row),
		.write_symbol      (write_symbol),
		.write_span        (write_span),
		.scroll_up_lines   (scroll_up_lines),
		.scroll_down_lines (scroll_down_lines)
	);

endmodule
